### hdl/flash_write_queue_sequencer_core_defines.svh
// Assertion macros shared by the flash write queue sequencer modules.
`ifndef FLASH_WRITE_QUEUE_SEQUENCER_CORE_DEFINES_SVH
`define FLASH_WRITE_QUEUE_SEQUENCER_CORE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define FWQS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define FWQS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define FWQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fwqs_pkg.sv
// Shared types and codes of the flash write queue sequencer.
`timescale 1ns / 1ps

package fwqs_pkg;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;

  // Item kind codes as they arrive on the input stream
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_POLL    = 2'd1;
  localparam logic [1:0] KIND_FLUSH   = 2'd2;

  // Operation after classification; unknown kinds become a no-op
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_POLL    = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_NOP     = 2'd3
  } fwqs_op_e;

  // Flash command codes
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ERASE   = 2'd1,
    CMD_PROGRAM = 2'd2
  } fwqs_cmd_e;

  // Stored step of the head request
  typedef enum logic [1:0] {
    STEP_WAIT_READY = 2'd0,
    STEP_WAIT_PROG  = 2'd1,
    STEP_WAIT_DONE  = 2'd2
  } fwqs_step_e;

  // Classified word passed from the front to the back
  typedef struct packed {
    fwqs_op_e            op;
    logic                ready;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   size;
    logic                aligned;
  } fwqs_item_t;

  // One ring entry
  typedef struct packed {
    logic                aligned;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   addr;
  } fwqs_entry_t;

endpackage

### hdl/fwqs_front.sv
// Front part: classifies input words and flags sector-aligned addresses.
`timescale 1ns / 1ps

module fwqs_front #(
  parameter int SECTOR_BYTES = 4096
) (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic                        flash_ready_i,
  input  logic [fwqs_pkg::ADDR_W-1:0] req_addr_i,
  input  logic [fwqs_pkg::SIZE_W-1:0] req_size_i,
  output logic                        wr_valid_o,
  input  logic                        wr_ready_i,
  output fwqs_pkg::fwqs_item_t        wr_item_o
);

  // Count trailing zero bits of the sector size
  function automatic int fwqs_tz(int v);
    int n;
    n = 0;
    for (int i = 0; i < 17; i++) begin
      if ((((v >> i) & 1) == 0) && (n == i)) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  // Inverse of an odd number modulo 2^32 by Newton iteration
  function automatic logic [31:0] fwqs_inv32(logic [31:0] o);
    logic [31:0] x;
    x = o;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - o * x);
    end
    return x;
  endfunction

  // Sector size = 2^TZ * ODD; divisibility by ODD uses the inverse trick
  localparam int          TZ       = fwqs_tz(SECTOR_BYTES);
  localparam int          ODD      = SECTOR_BYTES >> TZ;
  localparam logic [31:0] INV      = fwqs_inv32(32'(ODD));
  localparam logic [31:0] LIM      = 32'hFFFF_FFFF / ODD;
  localparam logic [31:0] LOW_MASK = 32'((64'd1 << TZ) - 64'd1);

  logic [31:0]         prod;
  logic                aligned;
  fwqs_pkg::fwqs_op_e  op;

  // Test alignment: low bits clear and address divisible by the odd factor
  assign prod    = 32'(req_addr_i * INV);
  assign aligned = ((req_addr_i & LOW_MASK) == 32'd0) && (prod <= LIM);

  // Decode the item kind
  always_comb begin
    unique case (kind_i)
      fwqs_pkg::KIND_ENQUEUE: op = fwqs_pkg::OP_ENQUEUE;
      fwqs_pkg::KIND_POLL:    op = fwqs_pkg::OP_POLL;
      fwqs_pkg::KIND_FLUSH:   op = fwqs_pkg::OP_FLUSH;
      default:                op = fwqs_pkg::OP_NOP;
    endcase
  end

  // Push the classified word into the queue
  assign in_ready_o        = wr_ready_i;
  assign wr_valid_o        = in_valid_i;
  assign wr_item_o.op      = op;
  assign wr_item_o.ready   = flash_ready_i;
  assign wr_item_o.addr    = req_addr_i;
  assign wr_item_o.size    = req_size_i;
  assign wr_item_o.aligned = aligned;

endmodule

### hdl/fwqs_fifo.sv
// Two-entry queue between the front and the back part.
`timescale 1ns / 1ps
`include "flash_write_queue_sequencer_core_defines.svh"

module fwqs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  fwqs_pkg::fwqs_item_t wr_item_i,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output fwqs_pkg::fwqs_item_t rd_item_o
);

  fwqs_pkg::fwqs_item_t entry_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

  `FWQS_ASSERT_ALWAYS(a_fifo_level, cnt_q != 2'd3, "queue level out of range")

endmodule

### hdl/fwqs_back.sv
// Back part: request ring, step sequencer and registered result word.
`timescale 1ns / 1ps
`include "flash_write_queue_sequencer_core_defines.svh"

module fwqs_back #(
  parameter  int QUEUE_DEPTH = 32,
  parameter  int PAGE_BYTES  = 256,
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int LEN_W       = $clog2(PAGE_BYTES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_valid_i,
  output logic                        rd_ready_o,
  input  fwqs_pkg::fwqs_item_t        rd_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic [1:0]                  command_o,
  output logic [fwqs_pkg::ADDR_W-1:0] command_address_o,
  output logic [LEN_W-1:0]            command_length_o,
  output logic [SLOT_W-1:0]           command_slot_o,
  output logic [fwqs_pkg::SIZE_W-1:0] command_data_offset_o,
  output logic                        request_done_o,
  output logic                        busy_res_o,
  output logic [CNT_W-1:0]            pending_count_o
);

  localparam int AW = fwqs_pkg::ADDR_W;
  localparam int SW = fwqs_pkg::SIZE_W;

  // Ring memory and its registered read port
  fwqs_pkg::fwqs_entry_t mem [QUEUE_DEPTH];
  fwqs_pkg::fwqs_entry_t rd_q;

  // Control state
  logic [SLOT_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  fwqs_pkg::fwqs_step_e st_q, st_d;
  logic [SW-1:0]        bw_q, bw_d;
  logic                 exec_q, exec_d;
  logic                 reload_q, reload_d;

  // Copy of the head request
  logic [AW-1:0]        haddr_q, haddr_d;
  logic [SW-1:0]        hsize_q, hsize_d;
  logic                 halign_q, halign_d;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic                 out_acc_q, acc_d;
  fwqs_pkg::fwqs_cmd_e  out_cmd_q, cmd_d;
  logic [AW-1:0]        out_addr_q, caddr_d;
  logic [LEN_W-1:0]     out_len_q, clen_d;
  logic [SLOT_W-1:0]    out_slot_q, cslot_d;
  logic [SW-1:0]        out_off_q, coff_d;
  logic                 out_done_q, done_d;
  logic                 out_busy_q;
  logic [CNT_W-1:0]     out_cnt_q;

  logic                 take;
  logic                 mem_we;
  logic [SLOT_W:0]      tail_sum;
  logic [SLOT_W-1:0]    tail;
  logic [SLOT_W-1:0]    head_inc;
  logic [AW-1:0]        cur_addr;
  logic [SW-1:0]        cur_size;
  logic                 cur_align;
  logic [SW-1:0]        prog_bw;
  logic [SW-1:0]        remains;
  logic                 big;
  logic [LEN_W-1:0]     chunk;
  logic [SW-1:0]        prog_bw_next;
  logic                 step_go;

  // Take a word when the result slot frees up and the head copy is valid
  assign rd_ready_o = !reload_q && (!out_valid_q || out_ready_i);
  assign take       = rd_valid_i && rd_ready_o;

  // Ring pointers with wrap at the depth
  assign tail_sum = {1'b0, head_q} + (SLOT_W + 1)'(count_q);
  assign tail     = (tail_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) ?
                    SLOT_W'(tail_sum - (SLOT_W + 1)'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
  assign head_inc = (head_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // An idle block starts on the word just enqueued; otherwise use the head copy
  assign cur_addr  = exec_q ? haddr_q  : rd_item_i.addr;
  assign cur_size  = exec_q ? hsize_q  : rd_item_i.size;
  assign cur_align = exec_q ? halign_q : rd_item_i.aligned;

  // Next program chunk
  assign prog_bw      = (st_q == fwqs_pkg::STEP_WAIT_READY) ? '0 : bw_q;
  assign remains      = cur_size - prog_bw;
  assign big          = remains > SW'(PAGE_BYTES);
  assign chunk        = big ? LEN_W'(PAGE_BYTES) : LEN_W'(remains);
  assign prog_bw_next = big ? prog_bw + SW'(PAGE_BYTES) : cur_size;

  // Sequencer: next state and result word
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    st_d        = st_q;
    bw_d        = bw_q;
    exec_d      = exec_q;
    reload_d    = 1'b0;
    haddr_d     = haddr_q;
    hsize_d     = hsize_q;
    halign_d    = halign_q;
    mem_we      = 1'b0;
    step_go     = 1'b0;
    acc_d       = 1'b0;
    cmd_d       = fwqs_pkg::CMD_NONE;
    caddr_d     = '0;
    clen_d      = '0;
    cslot_d     = '0;
    coff_d      = '0;
    done_d      = 1'b0;

    // Load the next head entry fetched after a pop
    if (reload_q) begin
      haddr_d  = rd_q.addr;
      hsize_d  = rd_q.size;
      halign_d = rd_q.aligned;
    end

    if (take) begin
      unique case (rd_item_i.op)
        fwqs_pkg::OP_ENQUEUE: begin
          if (count_q != CNT_W'(QUEUE_DEPTH)) begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
            acc_d   = 1'b1;
            if (!exec_q) begin
              exec_d   = 1'b1;
              haddr_d  = rd_item_i.addr;
              hsize_d  = rd_item_i.size;
              halign_d = rd_item_i.aligned;
              step_go  = 1'b1;
            end
          end
        end
        fwqs_pkg::OP_POLL: begin
          step_go = exec_q;
        end
        fwqs_pkg::OP_FLUSH: begin
          head_d  = tail;
          count_d = '0;
          st_d    = fwqs_pkg::STEP_WAIT_READY;
          bw_d    = '0;
          exec_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // One step of the head request
    if (step_go && rd_item_i.ready) begin
      unique case (st_q)
        fwqs_pkg::STEP_WAIT_READY, fwqs_pkg::STEP_WAIT_PROG: begin
          st_d    = fwqs_pkg::STEP_WAIT_DONE;
          cslot_d = head_q;
          if ((st_q == fwqs_pkg::STEP_WAIT_READY) && cur_align) begin
            cmd_d   = fwqs_pkg::CMD_ERASE;
            caddr_d = cur_addr;
            bw_d    = '0;
          end else begin
            cmd_d   = fwqs_pkg::CMD_PROGRAM;
            caddr_d = cur_addr + AW'(prog_bw);
            clen_d  = chunk;
            coff_d  = prog_bw;
            bw_d    = prog_bw_next;
          end
        end
        fwqs_pkg::STEP_WAIT_DONE: begin
          if (bw_q < cur_size) begin
            st_d = fwqs_pkg::STEP_WAIT_PROG;
          end else begin
            // Pop the finished request and fetch the next one
            bw_d     = '0;
            head_d   = head_inc;
            count_d  = count_q - 1'b1;
            done_d   = 1'b1;
            st_d     = fwqs_pkg::STEP_WAIT_READY;
            exec_d   = (count_q != CNT_W'(1));
            reload_d = (count_q != CNT_W'(1));
          end
        end
        default: begin
        end
      endcase
    end

    // Hold the result until taken
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      st_q        <= fwqs_pkg::STEP_WAIT_READY;
      bw_q        <= '0;
      exec_q      <= 1'b0;
      reload_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      st_q        <= st_d;
      bw_q        <= bw_d;
      exec_q      <= exec_d;
      reload_q    <= reload_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Head copy and result payload
  always_ff @(posedge clk_i) begin
    haddr_q  <= haddr_d;
    hsize_q  <= hsize_d;
    halign_q <= halign_d;
    if (take) begin
      out_acc_q  <= acc_d;
      out_cmd_q  <= cmd_d;
      out_addr_q <= caddr_d;
      out_len_q  <= clen_d;
      out_slot_q <= cslot_d;
      out_off_q  <= coff_d;
      out_done_q <= done_d;
      out_busy_q <= exec_d;
      out_cnt_q  <= count_d;
    end
  end

  // Ring write at the tail, read one past the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail] <= '{aligned: rd_item_i.aligned, size: rd_item_i.size,
                     addr: rd_item_i.addr};
    end
    rd_q <= mem[head_inc];
  end

  assign out_valid_o           = out_valid_q;
  assign accepted_o            = out_acc_q;
  assign command_o             = out_cmd_q;
  assign command_address_o     = out_addr_q;
  assign command_length_o      = out_len_q;
  assign command_slot_o        = out_slot_q;
  assign command_data_offset_o = out_off_q;
  assign request_done_o        = out_done_q;
  assign busy_res_o            = out_busy_q;
  assign pending_count_o       = out_cnt_q;

  `FWQS_ASSERT_IMPLY(a_idle_empty, !exec_q, count_q == '0, "idle with requests pending")
  `FWQS_ASSERT_NEXT(a_reload_once, reload_q, !reload_q, "head reload lasted two cycles")
  `FWQS_ASSERT_IMPLY(a_cmd_busy, out_valid_q && (out_cmd_q != fwqs_pkg::CMD_NONE),
                     out_busy_q, "command issued while idle")
  `FWQS_ASSERT_IMPLY(a_done_alone, out_valid_q && out_done_q,
                     (out_cmd_q == fwqs_pkg::CMD_NONE) && !out_acc_q, "done word carries a command")

endmodule

### hdl/flash_write_queue_sequencer_core.sv
// Top level of the flash write queue sequencer.
`timescale 1ns / 1ps

// Queues flash write requests in a ring of QUEUE_DEPTH entries and issues at
// most one erase or program command per result word. Enqueue, poll and flush
// words are taken one per clock while the output side is ready and no head
// reload is pending; each returns exactly one result word. When a request
// completes and more are pending, the sequencer pauses input while the next
// head entry is read from the ring memory, whose read port is registered. Ring
// entries need no clearing after reset: only written entries are ever read.
module flash_write_queue_sequencer_core #(
  parameter  int QUEUE_DEPTH  = 32,
  parameter  int PAGE_BYTES   = 256,
  parameter  int SECTOR_BYTES = 4096,
  localparam int SLOT_W       = $clog2(QUEUE_DEPTH),
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
  localparam int LEN_W        = $clog2(PAGE_BYTES + 1),
  localparam int OUT_BITS     = 1 + 2 + 32 + LEN_W + SLOT_W + 16 + 1 + 1 + CNT_W,
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // flash_ready, req_addr, req_size (lowest bit up), zero padded
  input  logic [55:0]      s_axis_tdata_i,
  // kind
  input  logic [1:0]       s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // accepted, command, command_address, command_length, command_slot,
  // command_data_offset, request_done, busy_res, pending_count, zero padded
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  fwqs_pkg::fwqs_item_t wr_item, rd_item;
  logic                 wr_valid, wr_ready, rd_valid, rd_ready;

  logic                 accepted;
  logic [1:0]           command;
  logic [31:0]          command_address;
  logic [LEN_W-1:0]     command_length;
  logic [SLOT_W-1:0]    command_slot;
  logic [15:0]          command_data_offset;
  logic                 request_done;
  logic                 busy_res;
  logic [CNT_W-1:0]     pending_count;

  // Classify incoming words
  fwqs_front #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_front (
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .kind_i        (s_axis_tuser_i),
    .flash_ready_i (s_axis_tdata_i[0]),
    .req_addr_i    (s_axis_tdata_i[32:1]),
    .req_size_i    (s_axis_tdata_i[48:33]),
    .wr_valid_o    (wr_valid),
    .wr_ready_i    (wr_ready),
    .wr_item_o     (wr_item)
  );

  // Decouple front and back
  fwqs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_item_i  (wr_item),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_item_o  (rd_item)
  );

  // Carry out the requests
  fwqs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .rd_valid_i            (rd_valid),
    .rd_ready_o            (rd_ready),
    .rd_item_i             (rd_item),
    .out_valid_o           (m_axis_tvalid_o),
    .out_ready_i           (m_axis_tready_i),
    .accepted_o            (accepted),
    .command_o             (command),
    .command_address_o     (command_address),
    .command_length_o      (command_length),
    .command_slot_o        (command_slot),
    .command_data_offset_o (command_data_offset),
    .request_done_o        (request_done),
    .busy_res_o            (busy_res),
    .pending_count_o       (pending_count)
  );

  // Pack the result word, first field lowest
  assign m_axis_tdata_o = OUT_W'({pending_count, busy_res, request_done, command_data_offset,
                                  command_slot, command_length, command_address, command,
                                  accepted});

endmodule

### sim/flash_write_queue_sequencer_core_tb.sv
// Self-checking testbench of the flash write queue sequencer core.
`timescale 1ns / 1ps

module flash_write_queue_sequencer_core_tb;

  localparam int RING_SLOTS   = 32;
  localparam int PAGE_LEN     = 256;
  localparam int SECTOR_LEN   = 4096;
  localparam int RANDOM_WORDS = 550;
  localparam int DRAIN_CYCLES = 20;

  // Kind code the block does not define; it must act as a no-op
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Progress of the head request between polls
  typedef enum logic [2:0] {
    STG_WAIT_READY,
    STG_CHECK_SECTOR,
    STG_WAIT_PROG,
    STG_PROGRAM,
    STG_WAIT_DONE
  } head_stage_e;

  // One input word before packing
  typedef struct packed {
    logic [1:0]  kind;
    logic        ready;
    logic [31:0] addr;
    logic [15:0] size;
  } flash_word_t;

  // Output word as it lies on m_axis_tdata_o, highest field first
  typedef struct packed {
    logic [6:0]  pad;
    logic [5:0]  pending;
    logic        busy;
    logic        done;
    logic [15:0] offset;
    logic [4:0]  slot;
    logic [8:0]  length;
    logic [31:0] address;
    logic [1:0]  command;
    logic        accepted;
  } flash_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = fwqs_pkg::KIND_POLL;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;

  flash_write_queue_sequencer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  flash_word_t   pending_words[$];
  flash_result_t results_due[$];
  int            total_words = 0;
  int            words_taken = 0;
  int            errors = 0;

  // Predictor state of the request ring and sequencer
  logic [31:0] ring_addr [RING_SLOTS];
  logic [15:0] ring_size [RING_SLOTS];
  logic [4:0]  head_slot = '0;
  logic [5:0]  queued = '0;
  head_stage_e stage = STG_WAIT_READY;
  logic [16:0] written = '0;
  logic        running = 1'b0;

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run one sequencer step on the head request with a single ready sample
  task automatic advance_head_request(input logic ready, inout flash_result_t res);
    logic [4:0]  slot;
    logic [31:0] addr;
    logic [16:0] size;
    logic [16:0] remains;
    logic [16:0] chunk;
    head_stage_e st;
    slot = head_slot;
    addr = ring_addr[slot];
    size = {1'b0, ring_size[slot]};
    st   = stage;
    if (st == STG_WAIT_READY) begin
      if (!ready) return;
      written = '0;
      st = STG_CHECK_SECTOR;
    end
    if (st == STG_CHECK_SECTOR) begin
      if (addr % SECTOR_LEN == 0) begin
        res.command = fwqs_pkg::CMD_ERASE;
        res.address = addr;
        res.slot    = slot;
        stage = STG_WAIT_DONE;
        return;
      end
      st = STG_WAIT_PROG;
    end
    if (st == STG_WAIT_PROG) begin
      if (!ready) begin
        stage = st;
        return;
      end
      st = STG_PROGRAM;
    end
    if (st == STG_PROGRAM) begin
      remains = (written < size) ? size - written : '0;
      chunk   = (remains > PAGE_LEN) ? 17'(PAGE_LEN) : remains;
      res.command = fwqs_pkg::CMD_PROGRAM;
      res.address = addr + 32'(written);
      res.length  = chunk[8:0];
      res.slot    = slot;
      res.offset  = written[15:0];
      written = (remains > PAGE_LEN) ? written + chunk : size;
      stage = STG_WAIT_DONE;
      return;
    end
    if (st == STG_WAIT_DONE) begin
      if (!ready) return;
      if (written < size) begin
        stage = STG_WAIT_PROG;
        return;
      end
      written   = '0;
      head_slot = head_slot + 5'd1;
      if (queued > 0) queued = queued - 6'd1;
      res.done = 1'b1;
      stage = STG_WAIT_READY;
      if (queued == 0) running = 1'b0;
    end
  endtask

  // Work out the result word of one accepted input word
  task automatic predict_flash_result(input flash_word_t w, output flash_result_t res);
    logic [4:0] idx;
    res = '0;
    res.command = fwqs_pkg::CMD_NONE;
    unique case (w.kind)
      fwqs_pkg::KIND_ENQUEUE: begin
        if (queued < RING_SLOTS) begin
          idx = head_slot + queued[4:0];
          ring_addr[idx] = w.addr;
          ring_size[idx] = w.size;
          queued = queued + 6'd1;
          res.accepted = 1'b1;
          if (!running) begin
            running = 1'b1;
            advance_head_request(w.ready, res);
          end
        end
      end
      fwqs_pkg::KIND_POLL: begin
        if (running) advance_head_request(w.ready, res);
      end
      fwqs_pkg::KIND_FLUSH: begin
        head_slot = head_slot + queued[4:0];
        queued  = '0;
        stage   = STG_WAIT_READY;
        written = '0;
        running = 1'b0;
      end
      default: ;
    endcase
    res.busy    = running;
    res.pending = queued;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic push_word(input logic [1:0] kind, input logic ready,
                           input logic [31:0] addr, input logic [15:0] size);
    flash_word_t w;
    w.kind  = kind;
    w.ready = ready;
    w.addr  = addr;
    w.size  = size;
    pending_words.push_back(w);
  endtask

  // Mostly small writes, some sector sized, a few of any length
  function automatic logic [15:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom_range(0, 600));
    if (pick < 97) return 16'($urandom_range(0, 4096));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] random_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 99) < 40) a[11:0] = '0;
    return a;
  endfunction

  function automatic logic random_ready(input int pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  // Idle percentages per phase: none, sender, receiver, both
  function automatic int sender_idle_pct(input int taken);
    int phase;
    phase = (total_words > 0) ? taken * 4 / total_words : 0;
    unique case (phase)
      1:       return 59;
      3:       return 36;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int taken);
    int phase;
    phase = (total_words > 0) ? taken * 4 / total_words : 0;
    unique case (phase)
      2:       return 59;
      3:       return 36;
      default: return 0;
    endcase
  endfunction

  // Driver: predict each accepted word, then present the next one
  always @(posedge clk_i or negedge rst_ni) begin
    flash_word_t   w;
    flash_result_t res;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        w.kind  = s_axis_tuser_i;
        w.ready = s_axis_tdata_i[0];
        w.addr  = s_axis_tdata_i[32:1];
        w.size  = s_axis_tdata_i[48:33];
        predict_flash_result(w, res);
        results_due.push_back(res);
        words_taken++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_words.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(words_taken)) begin
          w = pending_words.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= w.kind;
          s_axis_tdata_i  <= {7'd0, w.size, w.addr, w.ready};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    flash_result_t got;
    flash_result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = flash_result_t'(m_axis_tdata_o);
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got %0h", $time, m_axis_tdata_o);
        end else begin
          want = results_due.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("command", 32'(want.command), 32'(got.command));
          check_field("command_address", want.address, got.address);
          check_field("command_length", 32'(want.length), 32'(got.length));
          check_field("command_slot", 32'(want.slot), 32'(got.slot));
          check_field("command_data_offset", 32'(want.offset), 32'(got.offset));
          check_field("request_done", 32'(want.done), 32'(got.done));
          check_field("busy_res", 32'(want.busy), 32'(got.busy));
          check_field("pending_count", 32'(want.pending), 32'(got.pending));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= receiver_stall_pct(words_taken));
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n;
    int pick;
    int burst;
    int i;

    // Directed: idle poll, unused kind, one request through every stage
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(KIND_UNUSED,            1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(fwqs_pkg::KIND_ENQUEUE, 1'b0, 32'h0000_1000, 16'd300);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b0, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    // Zero length unaligned write at the top of the address space
    push_word(fwqs_pkg::KIND_ENQUEUE, 1'b1, 32'hFFFF_FF01, 16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    // Largest write, a second request queued behind it, then flush both
    push_word(fwqs_pkg::KIND_ENQUEUE, 1'b1, 32'hFFFF_F000, 16'hFFFF);
    push_word(fwqs_pkg::KIND_ENQUEUE, 1'b0, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_FLUSH,   1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    // Zero length aligned write: erase, then done without a program
    push_word(fwqs_pkg::KIND_ENQUEUE, 1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_POLL,    1'b1, 32'h0,         16'h0);
    push_word(fwqs_pkg::KIND_FLUSH,   1'b0, 32'h0,         16'h0);

    // Random: fill the ring once first, then mixed episodes
    n = 0;
    pick = 0;
    while (n < RANDOM_WORDS) begin
      if (n > 0) pick = $urandom_range(0, 99);
      if (pick < 4) begin
        for (i = 0; i < 34; i++)
          push_word(fwqs_pkg::KIND_ENQUEUE, random_ready(70), random_addr(), random_size());
        n += 34;
      end else if (pick < 40) begin
        burst = $urandom_range(1, 4);
        for (i = 0; i < burst; i++)
          push_word(fwqs_pkg::KIND_ENQUEUE, random_ready(70), random_addr(), random_size());
        n += burst;
      end else if (pick < 88) begin
        burst = $urandom_range(1, 12);
        for (i = 0; i < burst; i++)
          push_word(fwqs_pkg::KIND_POLL, random_ready(85), $urandom, 16'($urandom));
        n += burst;
      end else if (pick < 94) begin
        push_word(fwqs_pkg::KIND_FLUSH, random_ready(50), $urandom, 16'($urandom));
        n++;
      end else if (pick < 97) begin
        push_word(KIND_UNUSED, random_ready(50), $urandom, 16'($urandom));
        n++;
      end else begin
        burst = $urandom_range(1, 8);
        for (i = 0; i < burst; i++)
          push_word(fwqs_pkg::KIND_POLL, random_ready(50), $urandom, 16'($urandom));
        n += burst;
      end
    end
    total_words = pending_words.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to be taken and every result to arrive
    @(negedge clk_i);
    while (words_taken < total_words || s_axis_tvalid_i || results_due.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
